### src/tqjs_pkg.sv
// ----------------------------------------------------------------------------
// tqjs_pkg
// shared types and constants of the two-queue job sorter
// ----------------------------------------------------------------------------
package tqjs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 32;

  localparam int ID_W    = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 16;
  localparam int LABEL_W = 8;
  localparam int THR_W   = 16;

  // dump counters hold the sum of both queue counts (capped at 32)
  localparam int TOT_W = 7;

  localparam logic [THR_W-1:0] THR_RESET = 16'd7;

  // op queue between front and back
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;
  localparam logic SEL_FIFO   = 1'b0;
  localparam logic SEL_PRIO   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  burst;
    logic [LABEL_W-1:0] label;
  } job_t;

  // classified command handed from front to back
  typedef struct packed {
    logic dump;
    logic is_long;
    job_t job;
  } op_t;

  typedef struct packed {
    logic kind;
    logic queue_sel;
    logic full_drop;
    job_t job;
    logic empty_dump;
    logic last;
  } res_t;

endpackage

### src/tqjs_if.sv
// ----------------------------------------------------------------------------
// tqjs_if
// job and result channels of the two-queue job sorter
// ----------------------------------------------------------------------------
interface tqjs_job_if;
  import tqjs_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ID_W-1:0]    job_id;
  logic [PRIO_W-1:0]  job_priority;
  logic [TIME_W-1:0]  burst_time;
  logic [LABEL_W-1:0] label_byte;

  modport source (
    output valid, cmd, job_id, job_priority, burst_time, label_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, job_id, job_priority, burst_time, label_byte,
    output ready
  );
endinterface

interface tqjs_res_if;
  import tqjs_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic               queue_sel;
  logic               full_drop;
  logic [ID_W-1:0]    out_id;
  logic [PRIO_W-1:0]  out_priority;
  logic [TIME_W-1:0]  out_time;
  logic [LABEL_W-1:0] out_label;
  logic               empty_dump;
  logic               last;

  modport source (
    output valid, kind, queue_sel, full_drop, out_id, out_priority, out_time,
           out_label, empty_dump, last,
    input  ready
  );
  modport sink (
    input  valid, kind, queue_sel, full_drop, out_id, out_priority, out_time,
           out_label, empty_dump, last,
    output ready
  );
endinterface

### src/two_queue_job_sorter_core.sv
// ----------------------------------------------------------------------------
// two_queue_job_sorter_core
// sorts jobs into a fifo queue or a priority queue and dumps both in order
// ----------------------------------------------------------------------------
// usage
//   jobs: one word per command; cmd insert carries a job, cmd dump reads out
//     the fifo queue and then the priority queue without removing anything
//   results: one ack word per insert (queue chosen, full drop flag, job
//     echoed), one word per stored entry on a dump, last marks the final word
//   cfg_wr_en / cfg_wr_data: write of long_job_threshold, only while idle
// flow and throughput
//   an accepted word enters the op queue, the back end takes it from there
//   when idle with a free output register, and registers the ack there;
//   with results.ready high and no dump running the back end takes one
//   insert per cycle
//   a dump first loads its total in a setup step, then streams one entry per
//   cycle while results.ready is high; the entries streamed are capped at 32
//   an empty dump answers with a single empty_dump word like an insert
//   the pace is set by the back end sequencer, which serves one command at
//   a time and, unless stalled, one dump entry per cycle through the output register
// reset
//   both queues empty, threshold back to 7, op queue empty, output valid cleared
// stall
//   while results.ready is low the output word holds; the two-entry op queue
//   keeps taking words until it fills, then jobs.ready drops
// ----------------------------------------------------------------------------
module two_queue_job_sorter_core #(
  parameter int QUEUE_DEPTH = tqjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [tqjs_pkg::THR_W-1:0] cfg_wr_data,
  tqjs_job_if.sink                   jobs,
  tqjs_res_if.source                 results
);
  import tqjs_pkg::*;

  // classified words from the front
  op_t  push_op;
  logic push_valid;
  logic push_ready;

  // head of the op queue toward the back
  op_t  pop_op;
  logic pop_valid;
  logic pop_ready;

  // front: threshold register and classification
  tqjs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .jobs        (jobs),
    .push_op     (push_op),
    .push_valid  (push_valid),
    .push_ready  (push_ready)
  );

  // decouples acceptance from execution
  tqjs_opq u_opq (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // back: the two queues, insert and dump
  tqjs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (pop_op),
    .op_valid (pop_valid),
    .op_ready (pop_ready),
    .results  (results)
  );

endmodule

### src/tqjs_front.sv
// ----------------------------------------------------------------------------
// tqjs_front
// accepts words, holds the threshold register and classifies each job
// ----------------------------------------------------------------------------
module tqjs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [tqjs_pkg::THR_W-1:0] cfg_wr_data,
  tqjs_job_if.sink                  jobs,
  output tqjs_pkg::op_t             push_op,
  output logic                      push_valid,
  input  logic                      push_ready
);
  import tqjs_pkg::*;

  logic [THR_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  assign jobs.ready = push_ready;
  assign push_valid = jobs.valid;

  always_comb begin
    push_op.dump       = (jobs.cmd == CMD_DUMP);
    push_op.is_long    = (jobs.burst_time >= threshold);
    push_op.job.id     = jobs.job_id;
    push_op.job.prio   = jobs.job_priority;
    push_op.job.burst  = jobs.burst_time;
    push_op.job.label  = jobs.label_byte;
  end

endmodule

### src/tqjs_opq.sv
// ----------------------------------------------------------------------------
// tqjs_opq
// short queue of classified commands between front and back
// ----------------------------------------------------------------------------
module tqjs_opq (
  input  logic          clk,
  input  logic          rst,
  input  tqjs_pkg::op_t push_op,
  input  logic          push_valid,
  output logic          push_ready,
  output tqjs_pkg::op_t pop_op,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import tqjs_pkg::*;

  op_t                  slots [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr;
  logic [OPQ_PTR_W-1:0] rd_ptr;
  logic [OPQ_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != OPQ_CNT_W'(OPQ_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

### src/tqjs_back.sv
// ----------------------------------------------------------------------------
// tqjs_back
// fifo and sorted priority line, insert execution and dump sequencer
// ----------------------------------------------------------------------------
module tqjs_back #(
  parameter int QUEUE_DEPTH = tqjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tqjs_pkg::op_t op,
  input  logic          op_valid,
  output logic          op_ready,
  tqjs_res_if.source    results
);
  import tqjs_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  job_t             fifo_mem  [QUEUE_DEPTH];
  job_t             prio_line [QUEUE_DEPTH];
  job_t             ins_src   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge;

  logic [CNT_W-1:0] fifo_count;
  logic [CNT_W-1:0] prio_count;
  logic             state;
  logic [TOT_W-1:0] dump_k;
  logic [TOT_W-1:0] dump_total;
  logic             out_valid;
  res_t             out_reg;

  logic             out_free;
  logic             take;
  logic             fifo_full;
  logic             prio_full;
  logic             fifo_ins;
  logic             prio_ins;
  logic [TOT_W-1:0] sum;
  logic [TOT_W-1:0] total_cap;
  logic             from_fifo;
  logic [TOT_W-1:0] prio_off;
  logic [IDX_W-1:0] fifo_rd_idx;
  logic [IDX_W-1:0] prio_rd_idx;
  job_t             dump_job;
  logic             dump_last;

  assign out_free  = !out_valid || results.ready;
  assign op_ready  = (state == ST_IDLE) && out_free;
  assign take      = op_valid && op_ready;
  assign fifo_full = (fifo_count == CNT_W'(QUEUE_DEPTH));
  assign prio_full = (prio_count == CNT_W'(QUEUE_DEPTH));
  assign fifo_ins  = take && !op.dump && op.is_long && !fifo_full;
  assign prio_ins  = take && !op.dump && !op.is_long && !prio_full;

  assign sum       = TOT_W'(fifo_count) + TOT_W'(prio_count);
  assign total_cap = (sum > TOT_W'(MAX_RESULTS)) ? TOT_W'(MAX_RESULTS) : sum;

  assign from_fifo   = (dump_k < TOT_W'(fifo_count));
  assign prio_off    = dump_k - TOT_W'(fifo_count);
  assign fifo_rd_idx = dump_k[IDX_W-1:0];
  assign prio_rd_idx = prio_off[IDX_W-1:0];
  assign dump_job    = from_fifo ? fifo_mem[fifo_rd_idx] : prio_line[prio_rd_idx];
  assign dump_last   = ((dump_k + 1'b1) == dump_total);

  // insert position: stored entries at or above the new priority stay put
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_line
    assign ge[i] = (CNT_W'(i) < prio_count) && (prio_line[i].prio >= op.job.prio);
    if (i == 0) begin : g_head
      assign ins_src[i] = op.job;
    end else begin : g_body
      assign ins_src[i] = ge[i-1] ? op.job : prio_line[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      fifo_count <= '0;
      prio_count <= '0;
      dump_k     <= '0;
      dump_total <= '0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (!op.dump) begin
              out_valid <= 1'b1;
            end else if (total_cap == '0) begin
              out_valid <= 1'b1;
            end else begin
              state      <= ST_DUMP;
              dump_k     <= '0;
              dump_total <= total_cap;
            end
          end
          if (fifo_ins) begin
            fifo_count <= fifo_count + 1'b1;
          end
          if (prio_ins) begin
            prio_count <= prio_count + 1'b1;
          end
        end
        ST_DUMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            dump_k    <= dump_k + 1'b1;
            if (dump_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_ins) begin
      fifo_mem[fifo_count[IDX_W-1:0]] <= op.job;
    end
    if (prio_ins) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!ge[i]) begin
          prio_line[i] <= ins_src[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take) begin
      out_reg.last <= 1'b1;
      if (!op.dump) begin
        out_reg.kind       <= KIND_ACK;
        out_reg.queue_sel  <= op.is_long ? SEL_FIFO : SEL_PRIO;
        out_reg.full_drop  <= op.is_long ? fifo_full : prio_full;
        out_reg.job        <= op.job;
        out_reg.empty_dump <= 1'b0;
      end else begin
        out_reg.kind       <= KIND_ENTRY;
        out_reg.queue_sel  <= SEL_FIFO;
        out_reg.full_drop  <= 1'b0;
        out_reg.job        <= '0;
        out_reg.empty_dump <= 1'b1;
      end
    end else if (state == ST_DUMP && out_free) begin
      out_reg.kind       <= KIND_ENTRY;
      out_reg.queue_sel  <= from_fifo ? SEL_FIFO : SEL_PRIO;
      out_reg.full_drop  <= 1'b0;
      out_reg.job        <= dump_job;
      out_reg.empty_dump <= 1'b0;
      out_reg.last       <= dump_last;
    end
  end

  assign results.valid        = out_valid;
  assign results.kind         = out_reg.kind;
  assign results.queue_sel    = out_reg.queue_sel;
  assign results.full_drop    = out_reg.full_drop;
  assign results.out_id       = out_reg.job.id;
  assign results.out_priority = out_reg.job.prio;
  assign results.out_time     = out_reg.job.burst;
  assign results.out_label    = out_reg.job.label;
  assign results.empty_dump   = out_reg.empty_dump;
  assign results.last         = out_reg.last;

endmodule

### src/tqjs_checker.sv
// ----------------------------------------------------------------------------
// tqjs_checker
// port-level checks of the job sorter result channel
// ----------------------------------------------------------------------------
module tqjs_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic        full_drop,
  input logic [15:0] out_id,
  input logic [15:0] out_time,
  input logic        empty_dump,
  input logic        last
);
  import tqjs_pkg::*;

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word withdrawn while stalled");

  // an insert ack is marked last and is no empty dump word
  a_ack_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_ACK |-> last && !empty_dump)
    else $error("insert ack not a single last word");

  // empty dump word is a lone dump word with cleared id and time fields
  a_empty_dump: assert property (@(posedge clk) disable iff (rst)
    res_valid && empty_dump |-> kind == KIND_ENTRY && last && !full_drop
      && out_id == '0 && out_time == '0)
    else $error("malformed empty dump word");

  // a drop can only be reported on an insert
  a_drop_ack: assert property (@(posedge clk) disable iff (rst)
    res_valid && full_drop |-> kind == KIND_ACK)
    else $error("full drop on a dump word");

endmodule

bind two_queue_job_sorter_core tqjs_checker u_tqjs_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .kind       (results.kind),
  .full_drop  (results.full_drop),
  .out_id     (results.out_id),
  .out_time   (results.out_time),
  .empty_dump (results.empty_dump),
  .last       (results.last)
);
